// ===== hw/rtl/ird_pkg.sv =====
// shared types and constants of the ir distance estimator
`default_nettype none
package ird_pkg;

    localparam int unsigned MAX_SAMPLES = 256;
    localparam int unsigned CNT_W       = 9;
    localparam int unsigned SUM_W       = 16;
    localparam int unsigned NUM_W       = 34;
    localparam int unsigned DEN_W       = 25;
    localparam int unsigned Q_W         = 18;
    localparam int unsigned DVAL_W      = 17;

    // d = 475*a - 5355, distance = (K - 21404*d) / (200*d) truncated
    localparam logic [NUM_W-1:0]  DIST_K      = 34'd13056000000;
    localparam logic [14:0]       DIST_NUM_M  = 15'd21404;
    localparam logic [7:0]        DIST_DEN_M  = 8'd200;
    localparam logic [8:0]        DVAL_M      = 9'd475;
    localparam logic [DVAL_W-1:0] DVAL_OFS    = 17'd5355;
    localparam logic [7:0]        MIN_AVG     = 8'd12;
    localparam logic [15:0]       DIST_SAT    = 16'sd32767;

    typedef enum logic [2:0] {
        REG_TICK_DIVIDER = 3'd0,
        REG_SAMPLES      = 3'd1,
        REG_LOWER_LIMIT  = 3'd2,
        REG_TARGET       = 3'd3,
        REG_OFFSET       = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        SIDE_ERROR    = 2'd0,
        SIDE_CLOSE    = 2'd1,
        SIDE_PARALLEL = 2'd2,
        SIDE_FAR      = 2'd3
    } t_side;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_CHECK,
        S_PREP,
        S_DIST,
        S_DONE
    } t_back_state;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_job;

    typedef struct packed {
        logic [7:0]         lower_limit;
        logic signed [15:0] target;
        logic signed [15:0] offset;
    } t_back_cfg;

endpackage
`default_nettype wire

// ===== hw/rtl/ird_front.sv =====
// front end: tick decimation, sample summing and job creation
`default_nettype none
module ird_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [7:0]            i_sample,
    input  wire logic [7:0]            i_tick_divider,
    input  wire logic [8:0]            i_samples_per_estimate,
    output ird_pkg::t_job              o_job,
    output logic                       o_job_push
);

    logic [7:0]                  r_tick, n_tick;
    logic [ird_pkg::CNT_W-1:0]   r_kept, n_kept;
    logic [ird_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [7:0]                  tick_inc;
    logic [ird_pkg::CNT_W-1:0]   kept_inc;
    logic [ird_pkg::SUM_W-1:0]   sum_inc;
    logic [ird_pkg::CNT_W-1:0]   eff_count;

    always_comb begin
        if (i_samples_per_estimate == '0) begin
            eff_count = ird_pkg::CNT_W'(1);
        end else if (i_samples_per_estimate > ird_pkg::CNT_W'(ird_pkg::MAX_SAMPLES)) begin
            eff_count = ird_pkg::CNT_W'(ird_pkg::MAX_SAMPLES);
        end else begin
            eff_count = i_samples_per_estimate;
        end
    end

    assign tick_inc = r_tick + 8'd1;
    assign kept_inc = r_kept + ird_pkg::CNT_W'(1);
    assign sum_inc  = r_sum + ird_pkg::SUM_W'(i_sample);

    always_comb begin
        n_tick     = r_tick;
        n_kept     = r_kept;
        n_sum      = r_sum;
        o_job_push = 1'b0;
        o_job.sum   = sum_inc;
        o_job.count = eff_count;
        if (i_accept) begin
            n_tick = tick_inc;
            if (tick_inc == i_tick_divider) begin
                n_tick = '0;
                if (kept_inc >= eff_count) begin
                    o_job_push = 1'b1;
                    n_kept     = '0;
                    n_sum      = '0;
                end else begin
                    n_kept = kept_inc;
                    n_sum  = sum_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_kept <= '0;
            r_sum  <= '0;
        end else begin
            r_tick <= n_tick;
            r_kept <= n_kept;
            r_sum  <= n_sum;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ird_queue.sv =====
// two-entry job queue between front and back
`default_nettype none
module ird_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  ird_pkg::t_job              i_job,
    input  wire logic                  i_pop,
    output ird_pkg::t_job              o_job,
    output logic                       o_full,
    output logic                       o_empty
);

    ird_pkg::t_job r_mem [2];
    logic          r_wptr, r_rptr;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ird_div.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module ird_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ird_pkg::NUM_W-1:0]   i_num,
    input  wire logic [ird_pkg::DEN_W-1:0]   i_den,
    output logic                             o_done,
    output logic [ird_pkg::Q_W-1:0]          o_quot
);

    localparam int unsigned HI_W = ird_pkg::NUM_W - ird_pkg::Q_W;

    logic                          r_busy;
    logic [4:0]                    r_cnt;
    logic [ird_pkg::DEN_W-1:0]     r_den;
    logic [ird_pkg::DEN_W-1:0]     r_rem;
    logic [ird_pkg::Q_W-1:0]       r_num;
    logic [ird_pkg::Q_W-1:0]       r_quot;
    logic                          r_done;
    logic [ird_pkg::DEN_W:0]       trial;
    logic                          fits;

    // caller keeps num >> Q_W below den so the quotient fits
    assign trial = {r_rem, r_num[ird_pkg::Q_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= ird_pkg::DEN_W'(i_num[ird_pkg::NUM_W-1 -: HI_W]);
            r_num  <= i_num[ird_pkg::Q_W-1:0];
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? ird_pkg::DEN_W'(trial - {1'b0, r_den})
                           : trial[ird_pkg::DEN_W-1:0];
            r_num  <= {r_num[ird_pkg::Q_W-2:0], 1'b0};
            r_quot <= {r_quot[ird_pkg::Q_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(ird_pkg::Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// ===== hw/rtl/ird_back.sv =====
// back end: average, range check, linearization, classification, result register
`default_nettype none
module ird_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  ird_pkg::t_job              i_job,
    input  wire logic                  i_job_empty,
    output logic                       o_job_pop,
    input  ird_pkg::t_back_cfg         i_cfg,
    input  wire logic                  i_pop,
    output logic                       o_empty,
    output logic [7:0]                 o_average_raw,
    output logic                       o_in_range,
    output logic signed [15:0]         o_distance,
    output logic signed [16:0]         o_distance_change,
    output logic [1:0]                 o_side_state,
    output logic                       o_state_changed
);

    ird_pkg::t_back_state            r_state, n_state;
    logic [7:0]                      r_avg;
    logic                            r_in_range;
    logic [ird_pkg::DVAL_W-1:0]      r_dval;
    logic signed [15:0]              r_dist;
    logic signed [15:0]              r_last_dist;
    logic [1:0]                      r_last_side;
    logic                            r_out_valid;

    logic                            div_start;
    logic [ird_pkg::NUM_W-1:0]       div_num;
    logic [ird_pkg::DEN_W-1:0]       div_den;
    logic                            div_done;
    logic [ird_pkg::Q_W-1:0]         div_quot;
    logic                            out_load;
    logic                            out_free;
    logic signed [17:0]              shifted;
    ird_pkg::t_side                  side;
    logic signed [15:0]              res_dist;
    logic signed [16:0]              res_change;

    ird_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign out_free = !r_out_valid || i_pop;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ird_pkg::S_IDLE:  if (!i_job_empty) n_state = ird_pkg::S_AVG;
            ird_pkg::S_AVG:   if (div_done) n_state = ird_pkg::S_CHECK;
            ird_pkg::S_CHECK: begin
                if (r_avg < i_cfg.lower_limit || r_avg < ird_pkg::MIN_AVG) begin
                    n_state = ird_pkg::S_DONE;
                end else begin
                    n_state = ird_pkg::S_PREP;
                end
            end
            ird_pkg::S_PREP:  n_state = ird_pkg::S_DIST;
            ird_pkg::S_DIST:  if (div_done) n_state = ird_pkg::S_DONE;
            ird_pkg::S_DONE:  if (out_free) n_state = ird_pkg::S_IDLE;
            default:          n_state = ird_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        div_start = 1'b0;
        div_num   = ird_pkg::NUM_W'(i_job.sum);
        div_den   = ird_pkg::DEN_W'(i_job.count);
        o_job_pop = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            ird_pkg::S_IDLE: begin
                div_start = !i_job_empty;
                o_job_pop = !i_job_empty;
            end
            ird_pkg::S_PREP: begin
                div_start = 1'b1;
                div_num   = ird_pkg::DIST_K
                            - ird_pkg::NUM_W'(ird_pkg::DIST_NUM_M) * ird_pkg::NUM_W'(r_dval);
                div_den   = ird_pkg::DEN_W'(ird_pkg::DIST_DEN_M) * ird_pkg::DEN_W'(r_dval);
            end
            ird_pkg::S_DONE: out_load = out_free;
            default: ;
        endcase
    end

    // classification of the finished estimate
    assign shifted = 18'(r_dist) - 18'(i_cfg.offset);
    always_comb begin
        if (!r_in_range) begin
            side = ird_pkg::SIDE_ERROR;
        end else if (shifted < 18'(i_cfg.target)) begin
            side = ird_pkg::SIDE_CLOSE;
        end else if (shifted > 18'(i_cfg.target)) begin
            side = ird_pkg::SIDE_FAR;
        end else begin
            side = ird_pkg::SIDE_PARALLEL;
        end
    end
    assign res_dist   = r_in_range ? r_dist : r_last_dist;
    assign res_change = r_in_range ? (17'(r_dist) - 17'(r_last_dist)) : '0;

    always_ff @(posedge i_clk) begin
        case (r_state)
            ird_pkg::S_AVG: if (div_done) r_avg <= div_quot[7:0];
            ird_pkg::S_CHECK: begin
                r_in_range <= (r_avg >= i_cfg.lower_limit);
                r_dist     <= ird_pkg::DIST_SAT;
                r_dval     <= ird_pkg::DVAL_W'(ird_pkg::DVAL_M) * ird_pkg::DVAL_W'(r_avg)
                              - ird_pkg::DVAL_OFS;
            end
            ird_pkg::S_DIST: begin
                if (div_done) begin
                    r_dist <= (div_quot > ird_pkg::Q_W'(ird_pkg::DIST_SAT))
                              ? ird_pkg::DIST_SAT : div_quot[15:0];
                end
            end
            default: ;
        endcase
        if (out_load) begin
            o_average_raw     <= r_avg;
            o_in_range        <= r_in_range;
            o_distance        <= res_dist;
            o_distance_change <= res_change;
            o_side_state      <= side;
            o_state_changed   <= (side != r_last_side);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ird_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_last_dist <= '0;
            r_last_side <= ird_pkg::SIDE_ERROR;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_last_side <= side;
                if (r_in_range) begin
                    r_last_dist <= r_dist;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty = !r_out_valid;

`ifndef ASSERT_OFF
    a_dist_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ird_pkg::S_DIST) |-> r_in_range)
        else $error("distance division without in-range average");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> r_out_valid)
        else $error("result lost before pop");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ird_pkg::S_AVG || r_state == ird_pkg::S_DIST))
        else $error("divider finished outside a division state");
    a_job_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> !i_job_empty)
        else $error("job queue popped while empty");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/ir_distance_estimator.sv =====
// top level of the ir distance estimator
//
// input channel: one transaction per sensor tick (push while full is low)
// carrying the current 8-bit reading. ticks are decimated by tick_divider
// and kept samples summed; when samples_per_estimate are in, one estimate
// job goes into a two-entry queue and the front keeps taking ticks.
// the back end pops a job, divides the sum by the count on the shared
// restoring divider, checks the range and, when the average is at least
// lower_limit and 12, divides again for the linearized Q8.8 distance.
// the result register is loaded from the done state, which an estimate
// below either bound reaches straight from the range check; only then
// does the back end take its next job, while the front keeps taking ticks.
// result channel: a result waits in the output register while empty is low
// and leaves on pop. while it waits the back end holds its next result, the
// queue fills and full rises, stalling the input.
// configuration: write enable, index, data; write only while idle.
// reset (synchronous, active low) clears counters, sum, last distance and
// last state and loads the register defaults; queue and result are empty.
`default_nettype none
module ir_distance_estimator (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [7:0]           i_sample,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [7:0]                o_average_raw,
    output logic                      o_in_range,
    output logic signed [15:0]        o_distance,
    output logic signed [16:0]        o_distance_change,
    output logic [1:0]                o_side_state,
    output logic                      o_state_changed,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_idx,
    input  wire logic [15:0]          i_cfg_data
);

    logic [7:0]          r_tick_divider;
    logic [8:0]          r_samples;
    ird_pkg::t_back_cfg  r_back_cfg;

    ird_pkg::t_job       front_job;
    logic                front_push;
    ird_pkg::t_job       queue_job;
    logic                queue_full;
    logic                queue_empty;
    logic                queue_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_divider         <= 8'd1;
            r_samples              <= 9'd16;
            r_back_cfg.lower_limit <= 8'd0;
            r_back_cfg.target      <= 16'sd2560;
            r_back_cfg.offset      <= 16'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ird_pkg::REG_TICK_DIVIDER: r_tick_divider         <= i_cfg_data[7:0];
                ird_pkg::REG_SAMPLES:      r_samples              <= i_cfg_data[8:0];
                ird_pkg::REG_LOWER_LIMIT:  r_back_cfg.lower_limit <= i_cfg_data[7:0];
                ird_pkg::REG_TARGET:       r_back_cfg.target      <= i_cfg_data;
                ird_pkg::REG_OFFSET:       r_back_cfg.offset      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign full = queue_full;

    ird_front u_front (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_accept               (push && !queue_full),
        .i_sample               (i_sample),
        .i_tick_divider         (r_tick_divider),
        .i_samples_per_estimate (r_samples),
        .o_job                  (front_job),
        .o_job_push             (front_push)
    );

    ird_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .i_pop   (queue_pop),
        .o_job   (queue_job),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    ird_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job             (queue_job),
        .i_job_empty       (queue_empty),
        .o_job_pop         (queue_pop),
        .i_cfg             (r_back_cfg),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_average_raw     (o_average_raw),
        .o_in_range        (o_in_range),
        .o_distance        (o_distance),
        .o_distance_change (o_distance_change),
        .o_side_state      (o_side_state),
        .o_state_changed   (o_state_changed)
    );

endmodule
`default_nettype wire
